FILE: src/assert_macros.svh
// Assertion macros shared by the buddy free/coalesce RTL.
// Every macro samples on clk; the checked variants skip cycles while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clk edge, including edges during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/bfc_pkg.sv
// Package for the buddy free/coalesce block: field widths, mark encoding,
// sequencer states and the mark memory write bundle. No dependencies.
package bfc_pkg;

  localparam int PAGE_AW    = 11;
  localparam int PAGE_SLOTS = 2048;
  localparam int ORD_W      = 4;
  localparam int TYPE_W     = 3;
  localparam int MARK_W     = 5;
  localparam int COUNT_W    = 12;
  localparam int WIDE_W     = 16;
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [MARK_W-1:0]  MARK_EMPTY = '0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_MARK,
    ST_TAIL,
    ST_OUT
  } bfc_state_t;

  typedef struct packed {
    logic                 we;
    logic [PAGE_AW-1:0]   addr;
    logic [MARK_W-1:0]    data;
  } mark_wr_t;

  // Free-head mark word: head bit over the order.
  function automatic logic [MARK_W-1:0] head_word(input logic [ORD_W-1:0] ord);
    head_word = {1'b1, ord};
  endfunction

  function automatic logic [WIDE_W-1:0] ord_bit(input logic [ORD_W-1:0] ord);
    ord_bit = WIDE_W'(1) << ord;
  endfunction

  // Buddy of a block, widened so an address past the page map stays visible.
  function automatic logic [WIDE_W-1:0] buddy_of(input logic [PAGE_AW-1:0] idx,
                                                 input logic [ORD_W-1:0]   ord);
    buddy_of = WIDE_W'(idx) ^ ord_bit(ord);
  endfunction

  function automatic logic in_map(input logic [WIDE_W-1:0] addr);
    in_map = (addr[WIDE_W-1:PAGE_AW] == '0);
  endfunction

endpackage

FILE: src/bfc_mark_ram.sv
// Free-head mark memory: 2048 words, one write and one registered read port.
// Depends on bfc_pkg for widths and the write bundle.
module bfc_mark_ram (
  input  logic                         clk,
  input  bfc_pkg::mark_wr_t            wr,
  input  logic                         rd_en,
  input  logic [bfc_pkg::PAGE_AW-1:0]  rd_addr,
  output logic [bfc_pkg::MARK_W-1:0]   rd_data
);
  import bfc_pkg::*;

  logic [MARK_W-1:0] mem [PAGE_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/buddy_free_coalesce_unit.sv
// Buddy allocator free path with coalescing: top level.
// Depends on bfc_pkg, bfc_mark_ram and assert_macros.svh.
//
// Usage:
//   Input stream (in_*): one word per freed block. in_tdata carries the page
//   index and the block order, in_tuser the migrate type. Output stream
//   (out_*): one word per input word, in order. out_tdata carries the merged
//   start index and order, out_tuser the list type, the tail hint and the
//   misaligned flag. A misaligned index, or an order of MAX_ORDERS or more,
//   returns the request unchanged with misaligned set and leaves state alone.
// Reset: the free counts clear at once; the 2048-entry mark memory is then
//   swept to zero, one entry a cycle, so in_tready stays low after rst_n
//   rises until the sweep is done.
// Sequence: one item at a time. After the accept edge the block does its
//   buddy lookups in the mark memory (merges + 1, or just merges when
//   the chain reaches the top order; at most MAX_ORDERS - 1 lookups), then
//   writes the merged head, reads the next-higher buddy when it exists, and
//   loads the output register. A rejected item goes straight to the output
//   register. The lookups are bounded by the single read port of the mark
//   memory walking one order per cycle.
// Stall: the result sits in the output register until out_tready; the next
//   word is still accepted meanwhile and processed up to its own result, which
//   then waits for the register to drain.
module buddy_free_coalesce_unit #(
  parameter int MAX_ORDERS = 11
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // in_tdata: [10:0] page_index, [14:11] block_order, [15] zero
  input  logic [bfc_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: [2:0] mobility_type
  input  logic [bfc_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_tdata: [10:0] merged_index, [14:11] merged_order, [15] zero
  output logic [bfc_pkg::OUT_DATA_W-1:0]   out_tdata,
  // out_tuser: [2:0] list_type, [3] add_at_tail, [4] misaligned
  output logic [bfc_pkg::OUT_USER_W-1:0]   out_tuser
);
  import bfc_pkg::*;

  `include "assert_macros.svh"

  localparam int CNT_IW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
  // Highest order a block can merge into, and the limit for the tail check.
  localparam logic [ORD_W:0] LAST_ORD = (ORD_W+1)'(MAX_ORDERS - 1);
  localparam logic [ORD_W:0] TAIL_LIM = (ORD_W+1)'(MAX_ORDERS - 2);

  // Sequencer and payload registers.
  bfc_state_t           state_r, state_nxt;
  logic [PAGE_AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [PAGE_AW-1:0]   idx_r, idx_nxt;
  logic [ORD_W-1:0]     ord_r, ord_nxt;
  logic [TYPE_W-1:0]    type_r, type_nxt;
  logic                 tail_r, tail_nxt;
  logic                 misal_r, misal_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0] out_user_r, out_user_nxt;
  logic [COUNT_W-1:0]   free_cnt_r [MAX_ORDERS];

  // Mark memory port signals.
  mark_wr_t             mark_wr;
  logic                 rd_en;
  logic [WIDE_W-1:0]    rd_addr_w;
  logic [MARK_W-1:0]    rd_data;

  // Free count update requests.
  logic                 cnt_inc, cnt_dec;

  // Input unpacking and predicates.
  logic [PAGE_AW-1:0]   in_idx;
  logic [ORD_W-1:0]     in_ord;
  logic [WIDE_W-1:0]    in_buddy;
  logic                 in_misal;
  logic                 in_can_merge;
  logic                 accept;
  logic                 out_free;

  logic                 buddy_hit;
  logic [WIDE_W-1:0]    ord_mask;
  logic [WIDE_W-1:0]    cur_buddy;
  logic [PAGE_AW-1:0]   merge_idx;
  logic [ORD_W-1:0]     merge_ord;
  logic [WIDE_W-1:0]    merge_buddy;
  logic                 merge_more;
  logic [WIDE_W-1:0]    higher;
  logic                 tail_check;

  assign in_idx   = in_tdata[PAGE_AW-1:0];
  assign in_ord   = in_tdata[PAGE_AW +: ORD_W];
  assign in_buddy = buddy_of(in_idx, in_ord);
  // Reject an order past the table or any set bit below the order.
  assign in_misal = ({1'b0, in_ord} > LAST_ORD)
                 || ((WIDE_W'(in_idx) & (ord_bit(in_ord) - WIDE_W'(1))) != '0);
  assign in_can_merge = ({1'b0, in_ord} < LAST_ORD) && in_map(in_buddy);

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // Lookup result: the buddy of (idx_r, ord_r) was read last cycle.
  assign ord_mask    = ord_bit(ord_r);
  assign cur_buddy   = buddy_of(idx_r, ord_r);
  assign buddy_hit   = (rd_data == head_word(ord_r));
  assign merge_idx   = idx_r & ~ord_mask[PAGE_AW-1:0];
  assign merge_ord   = ord_r + ORD_W'(1);
  assign merge_buddy = buddy_of(merge_idx, merge_ord);
  assign merge_more  = ({1'b0, merge_ord} < LAST_ORD) && in_map(merge_buddy);

  // Next-higher buddy: other half of the grandparent block.
  assign higher     = (WIDE_W'(idx_r) & ~ord_mask) ^ (ord_mask << 1);
  assign tail_check = ({1'b0, ord_r} < TAIL_LIM) && in_map(higher);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_misal) begin
            state_nxt = ST_OUT;
          end else if (in_can_merge) begin
            state_nxt = ST_LOOKUP;
          end else begin
            state_nxt = ST_MARK;
          end
        end
      end
      ST_LOOKUP: begin
        if (!(buddy_hit && merge_more)) begin
          state_nxt = ST_MARK;
        end
      end
      ST_MARK: begin
        state_nxt = tail_check ? ST_TAIL : ST_OUT;
      end
      ST_TAIL: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    clr_cnt_nxt    = clr_cnt_r;
    idx_nxt        = idx_r;
    ord_nxt        = ord_r;
    type_nxt       = type_r;
    tail_nxt       = tail_r;
    misal_nxt      = misal_r;
    mark_wr        = '{we: 1'b0, addr: idx_r, data: MARK_EMPTY};
    rd_en          = 1'b0;
    rd_addr_w      = WIDE_W'(idx_r);
    cnt_inc        = 1'b0;
    cnt_dec        = 1'b0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    case (state_r)
      ST_CLEAR: begin
        // Sweep the mark memory to zero.
        mark_wr     = '{we: 1'b1, addr: clr_cnt_r, data: MARK_EMPTY};
        clr_cnt_nxt = clr_cnt_r + PAGE_AW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          idx_nxt   = in_idx;
          ord_nxt   = in_ord;
          type_nxt  = in_tuser[TYPE_W-1:0];
          tail_nxt  = 1'b0;
          misal_nxt = in_misal;
          // Launch the first buddy read straight from the input word.
          rd_en     = !in_misal && in_can_merge;
          rd_addr_w = in_buddy;
        end
      end
      ST_LOOKUP: begin
        if (buddy_hit) begin
          // Unmark the buddy, drop its count, step up one order.
          mark_wr = '{we: 1'b1, addr: cur_buddy[PAGE_AW-1:0], data: MARK_EMPTY};
          cnt_dec = 1'b1;
          idx_nxt = merge_idx;
          ord_nxt = merge_ord;
          // The next buddy lies outside the merged block: no clash with the write.
          rd_en     = merge_more;
          rd_addr_w = merge_buddy;
        end
      end
      ST_MARK: begin
        mark_wr   = '{we: 1'b1, addr: idx_r, data: head_word(ord_r)};
        cnt_inc   = 1'b1;
        rd_en     = tail_check;
        rd_addr_w = higher;
      end
      ST_TAIL: begin
        tail_nxt = (rd_data == head_word(ord_r + ORD_W'(1)));
      end
      ST_OUT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = OUT_DATA_W'({ord_r, idx_r});
          out_user_nxt   = {misal_r, tail_r, type_r};
        end
      end
      default: begin
      end
    endcase
  end

  bfc_mark_ram u_mark_ram (
    .clk     (clk),
    .wr      (mark_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_w[PAGE_AW-1:0]),
    .rd_data (rd_data)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    ord_r      <= ord_nxt;
    type_r     <= type_nxt;
    tail_r     <= tail_nxt;
    misal_r    <= misal_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  // Free counts per order, saturating at zero and at full scale.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ORDERS; i++) begin
        free_cnt_r[i] <= '0;
      end
    end else if (cnt_dec) begin
      if (free_cnt_r[ord_r[CNT_IW-1:0]] != '0) begin
        free_cnt_r[ord_r[CNT_IW-1:0]] <= free_cnt_r[ord_r[CNT_IW-1:0]] - COUNT_W'(1);
      end
    end else if (cnt_inc) begin
      if (free_cnt_r[ord_r[CNT_IW-1:0]] != COUNT_MAX) begin
        free_cnt_r[ord_r[CNT_IW-1:0]] <= free_cnt_r[ord_r[CNT_IW-1:0]] + COUNT_W'(1);
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `ASSERT_CLK(a_no_accept_in_clear, (state_r == ST_CLEAR) |-> !in_tready, "accept during clear")
  `ASSERT_CLK(a_lookup_order_range, (state_r == ST_LOOKUP) |-> ({1'b0, ord_r} < LAST_ORD), "lookup past last order")
  `ASSERT_CLK(a_lookup_write_clears, (state_r == ST_LOOKUP) && mark_wr.we |-> (mark_wr.data == MARK_EMPTY) && (mark_wr.addr != rd_addr_w[PAGE_AW-1:0] || !rd_en), "lookup write clash")
  `ASSERT_CLK(a_misal_no_tail, out_tvalid && out_tuser[4] |-> !out_tuser[3], "tail hint on rejected request")
  `ASSERT_CLK(a_cnt_ops_exclusive, !(cnt_inc && cnt_dec), "count inc and dec together")

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for buddy_free_coalesce_unit: directed frees, then random
// region frees and noise, each word checked against a hand result or the in-bench coalescing model.
// Depends on bfc_pkg and the unit RTL only.
module tb;
  import bfc_pkg::*;

  localparam int MAX_ORD     = 11;
  localparam int N_DIR       = 24;
  localparam int N_RANDOM    = 1700;
  localparam int CALM_TAIL   = 300;     // final stretch with no idling on either side
  localparam int CYCLE_LIMIT = 600000;

  // One result word, fields in the order they sit on the output bus.
  typedef struct packed {
    logic [PAGE_AW-1:0] merged_index;
    logic [ORD_W-1:0]   merged_order;
    logic [TYPE_W-1:0]  list_type;
    logic               add_at_tail;
    logic               misaligned;
  } free_res_t;

  // Directed table row. When hand_checked is set, the e_* fields are the
  // expected result; otherwise the model decides.
  typedef struct packed {
    logic [PAGE_AW-1:0] idx;
    logic [ORD_W-1:0]   ord;
    logic [TYPE_W-1:0]  mt;
    logic               hand_checked;
    logic [PAGE_AW-1:0] e_idx;
    logic [ORD_W-1:0]   e_ord;
    logic [TYPE_W-1:0]  e_mt;
    logic               e_tail;
    logic               e_mis;
  } free_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  // Bench copy of the allocator state.
  logic [MARK_W-1:0]  head_mark  [PAGE_SLOTS];
  logic [COUNT_W-1:0] free_count [MAX_ORD];

  free_res_t expected_frees [$];
  free_res_t got_res;
  free_res_t want_res;

  int gap_pct;
  int fail_count;
  int cycle_cnt;
  int words_sent;
  int rejected_cnt;
  int tail_cnt;
  int top_order_cnt;

  // Directed stimulus: fresh map, rejects, top order, a tail hint, a two-level
  // merge, a double free and a full chain from order 0 up to the top order.
  free_row_t dir_rows [N_DIR] = '{
    '{11'd0,    4'd0,  3'd0, 1'b1, 11'd0,    4'd0,  3'd0, 1'b0, 1'b0},
    '{11'd1,    4'd0,  3'd7, 1'b0, 11'd0,    4'd0,  3'd0, 1'b0, 1'b0},
    '{11'd1,    4'd1,  3'd3, 1'b1, 11'd1,    4'd1,  3'd3, 1'b0, 1'b1},
    '{11'd0,    4'd11, 3'd4, 1'b1, 11'd0,    4'd11, 3'd4, 1'b0, 1'b1},
    '{11'd2047, 4'd15, 3'd7, 1'b1, 11'd2047, 4'd15, 3'd7, 1'b0, 1'b1},
    '{11'd2047, 4'd0,  3'd5, 1'b0, 11'd0,    4'd0,  3'd0, 1'b0, 1'b0},
    '{11'd2046, 4'd0,  3'd6, 1'b0, 11'd0,    4'd0,  3'd0, 1'b0, 1'b0},
    '{11'd0,    4'd10, 3'd1, 1'b1, 11'd0,    4'd10, 3'd1, 1'b0, 1'b0},
    '{11'd16,   4'd2,  3'd2, 1'b0, 11'd0,    4'd0,  3'd0, 1'b0, 1'b0},
    '{11'd20,   4'd1,  3'd3, 1'b0, 11'd0,    4'd0,  3'd0, 1'b0, 1'b0},
    '{11'd22,   4'd1,  3'd4, 1'b0, 11'd0,    4'd0,  3'd0, 1'b0, 1'b0},
    '{11'd22,   4'd1,  3'd5, 1'b0, 11'd0,    4'd0,  3'd0, 1'b0, 1'b0},
    '{11'd1024, 4'd0,  3'd0, 1'b0, 11'd0,    4'd0,  3'd0, 1'b0, 1'b0},
    '{11'd1025, 4'd0,  3'd1, 1'b0, 11'd0,    4'd0,  3'd0, 1'b0, 1'b0},
    '{11'd1026, 4'd1,  3'd2, 1'b0, 11'd0,    4'd0,  3'd0, 1'b0, 1'b0},
    '{11'd1028, 4'd2,  3'd3, 1'b0, 11'd0,    4'd0,  3'd0, 1'b0, 1'b0},
    '{11'd1032, 4'd3,  3'd4, 1'b0, 11'd0,    4'd0,  3'd0, 1'b0, 1'b0},
    '{11'd1040, 4'd4,  3'd5, 1'b0, 11'd0,    4'd0,  3'd0, 1'b0, 1'b0},
    '{11'd1056, 4'd5,  3'd6, 1'b0, 11'd0,    4'd0,  3'd0, 1'b0, 1'b0},
    '{11'd1088, 4'd6,  3'd7, 1'b0, 11'd0,    4'd0,  3'd0, 1'b0, 1'b0},
    '{11'd1152, 4'd7,  3'd0, 1'b0, 11'd0,    4'd0,  3'd0, 1'b0, 1'b0},
    '{11'd1280, 4'd8,  3'd1, 1'b0, 11'd0,    4'd0,  3'd0, 1'b0, 1'b0},
    '{11'd1536, 4'd9,  3'd2, 1'b0, 11'd0,    4'd0,  3'd0, 1'b0, 1'b0},
    '{11'd512,  4'd10, 3'd6, 1'b1, 11'd512,  4'd10, 3'd6, 1'b0, 1'b1}
  };

  buddy_free_coalesce_unit #(
    .MAX_ORDERS (MAX_ORD)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [10:0] page_index, [14:11] block_order, [15] zero
    .in_tuser   (in_tuser),     // [2:0] mobility_type
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // [10:0] merged_index, [14:11] merged_order, [15] zero
    .out_tuser  (out_tuser)     // [2:0] list_type, [3] add_at_tail, [4] misaligned
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // True when page idx holds a free head of the given order.
  function automatic logic is_head(input int unsigned idx, input int unsigned ord);
    if (idx >= PAGE_SLOTS) return 1'b0;
    return head_mark[PAGE_AW'(idx)] == {1'b1, ORD_W'(ord)};
  endfunction

  // Free one block: walk up the orders while the buddy is a free head of the
  // same order, then mark the merged head and look at the next-higher buddy.
  function automatic free_res_t coalesce_free(input logic [PAGE_AW-1:0] idx_in,
                                              input logic [ORD_W-1:0]   ord_in,
                                              input logic [TYPE_W-1:0]  mt);
    int unsigned idx;
    int unsigned ord;
    int unsigned buddy;
    int unsigned higher;
    free_res_t   r;
    idx = idx_in;
    ord = ord_in;
    r.list_type   = mt;
    r.add_at_tail = 1'b0;
    r.misaligned  = 1'b0;
    // Reject: order past the top, or index not aligned to the order.
    if (ord >= MAX_ORD || (idx & ((1 << ord) - 1)) != 0) begin
      r.merged_index = idx_in;
      r.merged_order = ord_in;
      r.misaligned   = 1'b1;
      return r;
    end
    while (ord + 1 < MAX_ORD) begin
      buddy = idx ^ (1 << ord);
      if (!is_head(buddy, ord)) break;
      head_mark[PAGE_AW'(buddy)] = MARK_EMPTY;
      if (free_count[ORD_W'(ord)] != '0) free_count[ORD_W'(ord)]--;
      idx = idx & buddy;
      ord = ord + 1;
    end
    head_mark[PAGE_AW'(idx)] = {1'b1, ORD_W'(ord)};
    if (free_count[ORD_W'(ord)] != COUNT_MAX) free_count[ORD_W'(ord)]++;
    if (ord + 2 < MAX_ORD) begin
      higher = (idx & ~(1 << ord)) ^ (1 << (ord + 1));
      r.add_at_tail = is_head(higher, ord + 1);
    end
    r.merged_index = PAGE_AW'(idx);
    r.merged_order = ORD_W'(ord);
    return r;
  endfunction

  function automatic int field_diff(input string name, input int unsigned want,
                                    input int unsigned got);
    if (want == got) return 0;
    $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    return 1;
  endfunction

  // Offer one word, with an optional idle burst first; on accept, predict it.
  // tvalid stays high between back-to-back words and is only lowered for a gap.
  task automatic send_word(input logic [PAGE_AW-1:0] idx, input logic [ORD_W-1:0] ord,
                           input logic [TYPE_W-1:0] mt, input logic hand_checked,
                           input free_res_t hand_res);
    free_res_t r;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, ord, idx};
    in_tuser  <= mt;
    do @(posedge clk); while (!in_tready);
    r = coalesce_free(idx, ord, mt);
    expected_frees.push_back(hand_checked ? hand_res : r);
    words_sent++;
    if (r.misaligned) rejected_cnt++;
    if (r.add_at_tail) tail_cnt++;
    if (!r.misaligned && r.merged_order == ORD_W'(MAX_ORD - 1)) top_order_cnt++;
  endtask

  // Free every sub-block of one aligned region in shuffled order, so merges
  // climb from the sub-order up through the region and sometimes beyond it.
  task automatic free_region();
    int unsigned top;
    int unsigned sub;
    int unsigned base;
    int unsigned n;
    int unsigned i;
    int unsigned j;
    int unsigned t;
    int unsigned slots [$];
    top  = $urandom_range(1, MAX_ORD - 1);
    sub  = top - $urandom_range(1, (top < 4) ? top : 4);
    base = $urandom_range(0, PAGE_SLOTS - 1) & ~((1 << top) - 1);
    n    = 1 << (top - sub);
    for (i = 0; i < n; i++) slots.push_back(base + (i << sub));
    for (i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = slots[i];
      slots[i] = slots[j];
      slots[j] = t;
    end
    for (i = 0; i < n; i++)
      send_word(PAGE_AW'(slots[i]), ORD_W'(sub), TYPE_W'($urandom_range(0, 7)), 1'b0, '0);
  endtask

  // Receiver: random stall bursts at the current idle rate.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) < gap_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Check every accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res = {out_tdata[PAGE_AW-1:0], out_tdata[PAGE_AW+ORD_W-1:PAGE_AW],
                 out_tuser[2:0], out_tuser[3], out_tuser[4]};
      if (expected_frees.size() == 0) begin
        $display("%0t: unexpected result word, index %0d order %0d", $time,
                 got_res.merged_index, got_res.merged_order);
        fail_count++;
      end else begin
        want_res = expected_frees.pop_front();
        fail_count += field_diff("merged_index", want_res.merged_index, got_res.merged_index);
        fail_count += field_diff("merged_order", want_res.merged_order, got_res.merged_order);
        fail_count += field_diff("list_type", want_res.list_type, got_res.list_type);
        fail_count += field_diff("add_at_tail", want_res.add_at_tail, got_res.add_at_tail);
        fail_count += field_diff("misaligned", want_res.misaligned, got_res.misaligned);
      end
    end
  end

  // Watchdog: allows for the mark sweep after reset and worst-case idling.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_frees.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    int unsigned ord;
    int          pace_mark;
    int          i;
    free_res_t   hand_res;
    fail_count    = 0;
    cycle_cnt     = 0;
    words_sent    = 0;
    rejected_cnt  = 0;
    tail_cnt      = 0;
    top_order_cnt = 0;
    gap_pct       = 30;
    for (i = 0; i < PAGE_SLOTS; i++) head_mark[i] = MARK_EMPTY;
    for (i = 0; i < MAX_ORD; i++) free_count[i] = '0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part; the unit holds tready low during its mark sweep.
    for (i = 0; i < N_DIR; i++) begin
      hand_res = {dir_rows[i].e_idx, dir_rows[i].e_ord, dir_rows[i].e_mt,
                  dir_rows[i].e_tail, dir_rows[i].e_mis};
      send_word(dir_rows[i].idx, dir_rows[i].ord, dir_rows[i].mt,
                dir_rows[i].hand_checked, hand_res);
    end

    // Random part: mostly whole-region frees, mixed with aligned singles and noise.
    pace_mark = words_sent;
    while (words_sent < N_DIR + N_RANDOM) begin
      if (words_sent >= N_DIR + N_RANDOM - CALM_TAIL) begin
        gap_pct = 0;
      end else if (words_sent >= pace_mark) begin
        pace_mark = words_sent + 150;
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 15;
          default: gap_pct = 45;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        free_region();
      end else if (pick < 85) begin
        ord = $urandom_range(0, MAX_ORD - 1);
        send_word(PAGE_AW'($urandom_range(0, PAGE_SLOTS - 1) & ~((1 << ord) - 1)),
                  ORD_W'(ord), TYPE_W'($urandom_range(0, 7)), 1'b0, '0);
      end else begin
        send_word(PAGE_AW'($urandom_range(0, PAGE_SLOTS - 1)), ORD_W'($urandom_range(0, 15)),
                  TYPE_W'($urandom_range(0, 7)), 1'b0, '0);
      end
    end
    in_tvalid <= 1'b0;

    // Drain, then let a few more cycles pass to catch stray result words.
    while (expected_frees.size() != 0) @(posedge clk);
    repeat (MAX_ORD + 8) @(posedge clk);

    $display("summary: %0d frees checked, %0d rejected, %0d with tail hint,",
             words_sent, rejected_cnt, tail_cnt);
    $display("summary: %0d merged up to the top order, %0d field mismatches",
             top_order_cnt, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/bfc_pkg.sv
src/bfc_mark_ram.sv
src/buddy_free_coalesce_unit.sv
test/tb.sv
